FILE: hdl/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PRIO_BITS   = 8;
  localparam int VALUE_W     = 32;
  localparam int PRIO_W      = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                 valid;
    logic [VALUE_W-1:0]   value;
    logic [PRIO_BITS-1:0] prio;
  } slot_t;

  typedef struct packed {
    logic                 enq;
    logic                 deq;
    logic [VALUE_W-1:0]   value;
    logic [PRIO_BITS-1:0] prio;
  } ctrl_t;

endpackage : spq_pkg
`default_nettype wire

FILE: hdl/spq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps, takes the new item, or shifts.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire ctrl_t ctrl,
  input  wire slot_t left,
  input  wire logic  left_ge,
  input  wire slot_t right,
  output slot_t      slot,
  output logic       ge
);

  slot_t slot_next;

  assign ge = slot.valid & (slot.prio >= ctrl.prio);

  always_comb begin
    slot_next = slot;
    if (ctrl.deq) begin
      slot_next = right;
    end else if (ctrl.enq && !ge) begin
      if (left_ge) begin
        slot_next = '{valid: 1'b1, value: ctrl.value, prio: ctrl.prio};
      end else begin
        slot_next = left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
    slot.value <= slot_next.value;
    slot.prio  <= slot_next.prio;
  end

endmodule : spq_cell
`default_nettype wire

FILE: hdl/sorted_priority_queue_unit.sv
// An accepted item's result is registered in the output register.
// Throughput: one item per cycle while cmd_stall is low; each cell compares and shifts.
// cmd_stall is high only while a result waits and rsp_stall holds it.
// Reset clears the cell valid bits, the count and the output valid; no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue kept sorted in a chain of cells, front at cell 0.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
  import spq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire logic [1:0]         cmd,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic [PRIO_W-1:0]  prio,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output logic [VALUE_W-1:0]      out_value,
  output logic [PRIO_W-1:0]       out_prio,
  output logic [1:0]              status,
  output logic [CNT_W-1:0]        occupancy
);

  slot_t                  slots [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ge_vec;
  logic [QUEUE_DEPTH-1:0] valid_vec;
  ctrl_t                  ctrl;
  logic                   accept;
  logic                   full;
  logic                   empty;
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       cnt_next;
  status_t                st_next;
  logic                   front_out;

  assign cmd_stall = rsp_valid & rsp_stall;
  assign accept    = cmd_valid & ~cmd_stall;
  assign full      = slots[QUEUE_DEPTH-1].valid;
  assign empty     = ~slots[0].valid;

  always_comb begin
    ctrl.enq   = 1'b0;
    ctrl.deq   = 1'b0;
    ctrl.value = value;
    ctrl.prio  = prio[PRIO_BITS-1:0];
    cnt_next   = cnt;
    st_next    = ST_OK;
    front_out  = 1'b0;
    case (cmd)
      CMD_ENQ: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          ctrl.enq = accept;
          cnt_next = cnt + CNT_W'(1);
        end
      end
      CMD_DEQ: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          ctrl.deq  = accept;
          front_out = 1'b1;
          cnt_next  = cnt - CNT_W'(1);
        end
      end
      CMD_PEEK: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          front_out = 1'b1;
        end
      end
      default: begin
        st_next = ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    slot_t left_s;
    slot_t right_s;
    logic  left_ge_s;

    if (i == 0) begin : g_head
      assign left_s    = '0;
      assign left_ge_s = 1'b1;
    end else begin : g_body
      assign left_s    = slots[i-1];
      assign left_ge_s = ge_vec[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_s = '0;
    end else begin : g_mid
      assign right_s = slots[i+1];
    end

    spq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .left    (left_s),
      .left_ge (left_ge_s),
      .right   (right_s),
      .slot    (slots[i]),
      .ge      (ge_vec[i])
    );

    assign valid_vec[i] = slots[i].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value <= front_out ? slots[0].value : '0;
      out_prio  <= front_out ? PRIO_W'(slots[0].prio) : '0;
      status    <= st_next;
      occupancy <= cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_cnt_matches_cells: assert property (@(posedge clk) disable iff (rst)
    cnt == CNT_W'($countones(valid_vec)))
    else $error("count differs from valid cells");

  a_cells_packed: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + QUEUE_DEPTH'(1)) & valid_vec) == '0)
    else $error("valid cells not packed at the front");

  a_deq_shrinks: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_DEQ && !empty) |=> cnt == $past(cnt) - CNT_W'(1))
    else $error("dequeue did not shrink the queue");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_ENQ && full) |=> $stable(valid_vec) && status == ST_FULL)
    else $error("enqueue on full changed the queue");
`endif

endmodule : sorted_priority_queue_unit
`default_nettype wire
